### hdl/sorted_table_binary_search_macros.svh
// assertion macros shared by the table search block
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// property must hold in the same cycle
`define STBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// consequent must hold in the cycle after the trigger
`define STBS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);
`else
`define STBS_ASSERT(lbl, prop, msg)
`define STBS_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

### hdl/stbs_pkg.sv
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OUT_W       = 7;
  localparam int unsigned DATA_W      = 32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_key;
    logic append_wr;
    logic set_full;
    logic clear;
    logic p_init;
    logic a_load;
    logic q_step;
    logic p_wr;
    logic bs_init;
    logic bs_probe;
    logic bs_cmp;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic few;
    logic q_last;
    logic p_last;
    logic bs_open;
    logic hit;
  } sts_t;

endpackage

### hdl/sorted_table_binary_search.sv
// channel  dir  handshake                 word
// in       in   in_valid_i / in_ready_o   opcode_i, value_i
// out      out  out_valid_o / out_ready_i found_o, position_o, full_error_o, entry_total_o
//
// append, clear and unused codes: from idle to the final state, which loads the result word
// search: a sort if appended to since the last search or clear (n >= 2 entries), then a
//   binary search probing one entry at a time on the single read port, then the final state
// one word in flight; in_ready_o is high again once the result is in the output register
// rst_ni clears count and output valid and sets the sorted flag; table contents are not cleared
// a stalled output holds the block in its final state until the word is taken
module sorted_table_binary_search (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         opcode_i,
  input  logic signed [stbs_pkg::DATA_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic [stbs_pkg::OUT_W-1:0]         position_o,
  output logic                               full_error_o,
  output logic [stbs_pkg::OUT_W-1:0]         entry_total_o
);

  stbs_pkg::cmd_t cmd;
  stbs_pkg::sts_t sts;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  stbs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .found_o       (found_o),
    .position_o    (position_o),
    .full_error_o  (full_error_o),
    .entry_total_o (entry_total_o)
  );

endmodule

### hdl/stbs_dpath.sv
`include "sorted_table_binary_search_macros.svh"

module stbs_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  stbs_pkg::cmd_t                     cmd_i,
  output stbs_pkg::sts_t                     sts_o,
  input  logic signed [stbs_pkg::DATA_W-1:0] value_i,
  output logic                               found_o,
  output logic [stbs_pkg::OUT_W-1:0]         position_o,
  output logic                               full_error_o,
  output logic [stbs_pkg::OUT_W-1:0]         entry_total_o
);

  logic signed [stbs_pkg::DATA_W-1:0] mem [stbs_pkg::TABLE_DEPTH];
  logic signed [stbs_pkg::DATA_W-1:0] rdata_q;
  logic signed [stbs_pkg::DATA_W-1:0] key_q;
  logic signed [stbs_pkg::DATA_W-1:0] a_q, a_d;

  logic [stbs_pkg::CNT_W-1:0] count_q, count_d;
  logic [stbs_pkg::IDX_W-1:0] p_q, p_d;
  logic [stbs_pkg::IDX_W-1:0] q_q, q_d;
  logic [stbs_pkg::CNT_W-1:0] lo_q, lo_d;
  logic [stbs_pkg::CNT_W-1:0] hi_q, hi_d;
  logic [stbs_pkg::IDX_W-1:0] mid_q;
  logic [stbs_pkg::CNT_W-1:0] pos_q, pos_d;
  logic                       found_q, found_d;
  logic                       full_q, full_d;

  logic [stbs_pkg::CNT_W:0]   mid_sum;
  logic [stbs_pkg::IDX_W-1:0] mid;
  logic [stbs_pkg::IDX_W-1:0] raddr;
  logic                       we;
  logic [stbs_pkg::IDX_W-1:0] waddr;
  logic signed [stbs_pkg::DATA_W-1:0] wdata;
  logic                       swap;

  // lo < hi here, so the sum is never negative and the shift is the halving
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (stbs_pkg::CNT_W + 1)'(1);
  assign mid     = mid_sum[stbs_pkg::IDX_W:1];
  assign swap    = a_q > rdata_q;

  assign sts_o.full    = count_q == stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH);
  assign sts_o.few     = count_q < stbs_pkg::CNT_W'(2);
  assign sts_o.q_last  = (stbs_pkg::CNT_W'(q_q) + stbs_pkg::CNT_W'(1)) == count_q;
  assign sts_o.p_last  = (stbs_pkg::CNT_W'(p_q) + stbs_pkg::CNT_W'(2)) == count_q;
  assign sts_o.bs_open = lo_q < hi_q;
  assign sts_o.hit     = rdata_q == key_q;

  always_comb begin
    priority if (cmd_i.p_init) begin
      raddr = '0;
    end else if (cmd_i.a_load) begin
      raddr = q_q;
    end else if (cmd_i.q_step) begin
      raddr = q_q + stbs_pkg::IDX_W'(1);
    end else if (cmd_i.p_wr) begin
      raddr = p_q + stbs_pkg::IDX_W'(1);
    end else if (cmd_i.bs_probe) begin
      raddr = mid;
    end else begin
      raddr = p_q;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = p_q;
    wdata = a_q;
    priority if (cmd_i.append_wr) begin
      we    = 1'b1;
      waddr = count_q[stbs_pkg::IDX_W-1:0];
      wdata = value_i;
    end else if (cmd_i.q_step) begin
      we    = swap;
      waddr = q_q;
    end else if (cmd_i.p_wr) begin
      we    = 1'b1;
    end else begin
      we    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append_wr) begin
      count_d = count_q + stbs_pkg::CNT_W'(1);
    end else if (cmd_i.clear) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    p_d     = p_q;
    q_d     = q_q;
    a_d     = a_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    found_d = found_q;
    pos_d   = pos_q;
    full_d  = full_q;
    if (cmd_i.load_key) begin
      found_d = 1'b0;
      pos_d   = '0;
      full_d  = cmd_i.set_full;
    end
    if (cmd_i.p_init) begin
      p_d = '0;
      q_d = stbs_pkg::IDX_W'(1);
    end
    if (cmd_i.a_load) begin
      a_d = rdata_q;
    end
    if (cmd_i.q_step) begin
      q_d = q_q + stbs_pkg::IDX_W'(1);
      if (swap) begin
        a_d = rdata_q;
      end
    end
    if (cmd_i.p_wr) begin
      p_d = p_q + stbs_pkg::IDX_W'(1);
      q_d = p_q + stbs_pkg::IDX_W'(2);
    end
    if (cmd_i.bs_init) begin
      lo_d = '0;
      hi_d = count_q;
    end
    if (cmd_i.bs_cmp) begin
      if (rdata_q == key_q) begin
        found_d = 1'b1;
        pos_d   = stbs_pkg::CNT_W'(mid_q) + stbs_pkg::CNT_W'(1);
      end else if (key_q > rdata_q) begin
        lo_d = stbs_pkg::CNT_W'(mid_q) + stbs_pkg::CNT_W'(1);
      end else begin
        hi_d = stbs_pkg::CNT_W'(mid_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    q_q     <= q_d;
    a_q     <= a_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    full_q  <= full_d;
    if (cmd_i.load_key) begin
      key_q <= value_i;
    end
    if (cmd_i.bs_probe) begin
      mid_q <= mid;
    end
    if (cmd_i.out_load) begin
      found_o       <= found_q;
      position_o    <= stbs_pkg::OUT_W'(pos_q);
      full_error_o  <= full_q;
      entry_total_o <= stbs_pkg::OUT_W'(count_q);
    end
  end

  `STBS_ASSERT(a_count_range, count_q <= stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH), "count overflow")
  `STBS_ASSERT(a_append_room, !cmd_i.append_wr || !sts_o.full, "append into full table")
  `STBS_ASSERT(a_probe_range, !cmd_i.bs_probe || (stbs_pkg::CNT_W'(mid) < count_q), "probe beyond count")

endmodule

### hdl/stbs_ctrl.sv
`include "sorted_table_binary_search_macros.svh"

module stbs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     opcode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output stbs_pkg::cmd_t cmd_o,
  input  stbs_pkg::sts_t sts_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SRT_A  = 3'd1;
  localparam logic [2:0] S_SRT_Q  = 3'd2;
  localparam logic [2:0] S_SRT_W  = 3'd3;
  localparam logic [2:0] S_BS_CHK = 3'd4;
  localparam logic [2:0] S_BS_CMP = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       sorted_q, sorted_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    sorted_d = sorted_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = S_FIN;
          unique case (opcode_i)
            stbs_pkg::OP_APPEND: begin
              cmd_o.append_wr = !sts_i.full;
              cmd_o.set_full  = sts_i.full;
              if (!sts_i.full) begin
                sorted_d = 1'b0;
              end
            end
            stbs_pkg::OP_SEARCH: begin
              sorted_d = 1'b1;
              if (!sorted_q && !sts_i.few) begin
                cmd_o.p_init = 1'b1;
                state_d      = S_SRT_A;
              end else begin
                cmd_o.bs_init = 1'b1;
                state_d       = S_BS_CHK;
              end
            end
            stbs_pkg::OP_CLEAR: begin
              cmd_o.clear = 1'b1;
              sorted_d    = 1'b1;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_SRT_A: begin
        cmd_o.a_load = 1'b1;
        state_d      = S_SRT_Q;
      end
      S_SRT_Q: begin
        cmd_o.q_step = 1'b1;
        if (sts_i.q_last) begin
          state_d = S_SRT_W;
        end
      end
      S_SRT_W: begin
        // write back the minimum held for this slot
        cmd_o.p_wr = 1'b1;
        if (sts_i.p_last) begin
          cmd_o.bs_init = 1'b1;
          state_d       = S_BS_CHK;
        end else begin
          state_d = S_SRT_A;
        end
      end
      S_BS_CHK: begin
        if (sts_i.bs_open) begin
          cmd_o.bs_probe = 1'b1;
          state_d        = S_BS_CMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_BS_CMP: begin
        cmd_o.bs_cmp = 1'b1;
        state_d      = sts_i.hit ? S_FIN : S_BS_CHK;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sorted_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sorted_q    <= sorted_d;
      out_valid_q <= out_valid_d;
    end
  end

  `STBS_ASSERT_NEXT(a_sort_start, accept && (opcode_i == stbs_pkg::OP_SEARCH) && !sorted_q && !sts_i.few, state_q == S_SRT_A, "unsorted search skipped sort")
  `STBS_ASSERT_NEXT(a_fin_word, (state_q == S_FIN) && !out_valid_q, out_valid_q && (state_q == S_IDLE), "result word not issued")
  `STBS_ASSERT_NEXT(a_cmp_next, state_q == S_BS_CMP, (state_q == S_BS_CHK) || (state_q == S_FIN), "bad search step")

endmodule

### sim/table_search_check.sv
`timescale 1ns / 100ps

module table_search_check (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [1:0]                         opcode_i,
  input  logic signed [stbs_pkg::DATA_W-1:0] value_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic                               found_i,
  input  logic [stbs_pkg::OUT_W-1:0]         position_i,
  input  logic                               full_error_i,
  input  logic [stbs_pkg::OUT_W-1:0]         entry_total_i,
  output int unsigned                        words_pending_o,
  output int unsigned                        mismatches_o,
  output int unsigned                        words_checked_o,
  output int unsigned                        hits_o,
  output int unsigned                        drops_o
);
  import stbs_pkg::*;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] position;
    logic             full_error;
    logic [OUT_W-1:0] entry_total;
  } response_t;

  // shadow copy of the table
  logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
  int                       held     = 0;
  bit                       in_order = 1'b1;

  response_t   awaited_q [$];
  int unsigned mismatch_total = 0;
  int unsigned checked_total  = 0;
  int unsigned hit_total      = 0;
  int unsigned drop_total     = 0;

  assign mismatches_o    = mismatch_total;
  assign words_checked_o = checked_total;
  assign hits_o          = hit_total;
  assign drops_o         = drop_total;

  function automatic response_t next_response(input logic [1:0]              op,
                                              input logic signed [DATA_W-1:0] key);
    response_t                r;
    int                       lo;
    int                       hi;
    int                       mid;
    int                       i;
    int                       j;
    logic signed [DATA_W-1:0] tmp;
    r = '0;
    case (op)
      OP_APPEND: begin
        if (held >= TABLE_DEPTH) begin
          r.full_error = 1'b1;
        end else begin
          entries[held] = key;
          held++;
          in_order = 1'b0;
        end
      end
      OP_SEARCH: begin
        if (!in_order) begin
          for (i = 1; i < held; i++) begin
            tmp = entries[i];
            j = i - 1;
            while (j >= 0 && entries[j] > tmp) begin
              entries[j + 1] = entries[j];
              j--;
            end
            entries[j + 1] = tmp;
          end
          in_order = 1'b1;
        end
        lo = 0;
        hi = held - 1;
        // first equal entry that the probe sequence lands on wins
        while (lo <= hi && !r.found) begin
          mid = (lo + hi) / 2;
          if (key > entries[mid]) begin
            lo = mid + 1;
          end else if (key < entries[mid]) begin
            hi = mid - 1;
          end else begin
            r.found    = 1'b1;
            r.position = OUT_W'(mid + 1);
          end
        end
      end
      OP_CLEAR: begin
        held     = 0;
        in_order = 1'b1;
      end
      default: ;
    endcase
    r.entry_total = OUT_W'(held);
    return r;
  endfunction

  always @(posedge clk_i) begin
    response_t want;
    response_t got;
    if (rst_ni) begin
      // the word leaving is always older than one entering at the same edge
      if (out_valid_i && out_ready_i) begin
        got = {found_i, position_i, full_error_i, entry_total_i};
        if (awaited_q.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("%0t: result word with nothing awaited: found=%0d pos=%0d full=%0d total=%0d",
                     $time, got.found, got.position, got.full_error, got.entry_total);
          end
        end else begin
          want = awaited_q.pop_front();
          checked_total++;
          if (got.found !== want.found || got.position !== want.position ||
              got.full_error !== want.full_error || got.entry_total !== want.entry_total) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("%0t: result mismatch: expected found=%0d pos=%0d full=%0d total=%0d",
                       $time, want.found, want.position, want.full_error, want.entry_total);
              $display("%0t:                  actual found=%0d pos=%0d full=%0d total=%0d",
                       $time, got.found, got.position, got.full_error, got.entry_total);
            end
          end
          if (want.found) hit_total++;
          if (want.full_error) drop_total++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_q.push_back(next_response(opcode_i, value_i));
      end
      words_pending_o <= awaited_q.size();
    end
  end

endmodule

### sim/sorted_table_binary_search_tb.sv
`timescale 1ns / 100ps

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam int unsigned WORD_TARGET = 600;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AT     = 250;
  localparam int unsigned STALL_LIMIT = 20000;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                opcode_i    = OP_APPEND;
  logic signed [DATA_W-1:0]  value_i     = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      found_o;
  logic [OUT_W-1:0]          position_o;
  logic                      full_error_o;
  logic [OUT_W-1:0]          entry_total_o;

  int unsigned words_pending;
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned hits;
  int unsigned drops;

  int unsigned items_sent  = 0;
  int unsigned words_taken = 0;
  int unsigned op_count [4] = '{default: 0};
  bit          quiet_send  = 1'b0;
  bit          quiet_take  = 1'b0;

  // values appended since the last clear, used to aim searches
  logic signed [DATA_W-1:0] held_values [$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sorted_table_binary_search dut (.*);

  table_search_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .opcode_i       (opcode_i),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_i        (found_o),
    .position_i     (position_o),
    .full_error_i   (full_error_o),
    .entry_total_i  (entry_total_o),
    .words_pending_o(words_pending),
    .mismatches_o   (mismatches),
    .words_checked_o(words_checked),
    .hits_o         (hits),
    .drops_o        (drops)
  );

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      // narrow range so duplicates are common
      1, 2: return $signed($urandom_range(16)) - 32'sd8;
      default: return $signed($urandom);
    endcase
  endfunction

  // called just after a rising clk_i; returns once the word has been accepted
  task automatic send_word(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    if (items_sent % 40 == 0) quiet_send = ($urandom_range(3) == 0);
    gap = quiet_send ? 0 : $urandom_range(13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    op_count[op]++;
    if (op != OP_SPARE) items_sent++;
  endtask

  task automatic append_value(input logic signed [DATA_W-1:0] val);
    if (held_values.size() < TABLE_DEPTH) held_values.push_back(val);
    send_word(OP_APPEND, val);
  endtask

  task automatic clear_table();
    held_values.delete();
    send_word(OP_CLEAR, $signed($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  // receiver
  initial begin
    int unsigned gap;
    forever begin
      if (words_taken % 40 == 0) quiet_take = ($urandom_range(3) == 0);
      gap = quiet_take ? 0 : $urandom_range(13);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      words_taken++;
      // long back-pressure while the sender keeps offering
      if (words_taken == HOLD_AT) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("FAIL sorted_table_binary_search");
    $finish;
  end

  initial begin
    int unsigned              episodes;
    int unsigned              rounds;
    int unsigned              burst;
    bit                       fill;
    logic signed [DATA_W-1:0] key;
    episodes = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_word(OP_SEARCH, 32'sd0);             // empty table
    send_word(OP_SPARE, -32'sd1);
    append_value(32'sh7FFF_FFFF);
    append_value(32'sh8000_0000);
    append_value(32'sd0);
    append_value(-32'sd1);
    append_value(32'sd5);
    append_value(32'sd5);
    append_value(32'sd5);
    send_word(OP_SEARCH, 32'sh7FFF_FFFF);
    send_word(OP_SEARCH, 32'sh8000_0000);
    send_word(OP_SEARCH, 32'sd5);             // duplicates
    send_word(OP_SEARCH, 32'sd3);             // absent
    send_word(OP_SEARCH, -32'sd1);
    send_word(OP_SPARE, 32'sd0);
    append_value(32'sd1);                     // table unsorted again
    send_word(OP_SEARCH, 32'sd1);
    clear_table();
    send_word(OP_SEARCH, 32'sd5);             // old words no longer visible
    append_value(32'sd7);
    send_word(OP_SEARCH, 32'sd7);
    send_word(OP_SEARCH, 32'sd8);
    wait_drained();

    // random part: mostly clear / append / search episodes, some noise
    while (items_sent < WORD_TARGET) begin
      episodes++;
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(1, 8)) send_word(2'($urandom_range(3)), $signed($urandom));
      end else begin
        fill = (episodes == 3) || ($urandom_range(9) == 0);
        if (fill) wait_drained();
        clear_table();
        rounds = $urandom_range(1, 3);
        for (int r = 0; r < rounds; r++) begin
          burst = (fill && r == 0) ? TABLE_DEPTH + $urandom_range(1, 4) : $urandom_range(1, 12);
          repeat (burst) append_value(pick_value());
          repeat ($urandom_range(1, 6)) begin
            if (held_values.size() == 0 || $urandom_range(3) == 0) begin
              key = pick_value();
            end else begin
              key = held_values[$urandom_range(held_values.size() - 1)];
              // near misses next to stored values
              if ($urandom_range(3) == 0) key = key + ($urandom_range(1) ? 32'sd1 : -32'sd1);
            end
            send_word(OP_SEARCH, key);
          end
        end
      end
    end

    wait_drained();
    repeat (64) @(posedge clk_i);
    $display("covered %0d appends, %0d searches, %0d clears, %0d unused codes; %0d results checked",
             op_count[OP_APPEND], op_count[OP_SEARCH], op_count[OP_CLEAR], op_count[OP_SPARE],
             words_checked);
    $display("%0d searches hit, %0d appends dropped on a full table, %0d mismatches",
             hits, drops, mismatches);
    if (mismatches == 0 && words_pending == 0) begin
      $display("PASS sorted_table_binary_search");
    end else begin
      $display("FAIL sorted_table_binary_search");
    end
    $finish;
  end

endmodule
